@@ sv/tcp_syn_header_extractor_top_macros.svh @@
// Assertion macros used by the result buffer of the TCP SYN header extractor.
`ifndef TCP_SYN_HEADER_EXTRACTOR_TOP_MACROS_SVH
`define TCP_SYN_HEADER_EXTRACTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TSH_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`define TSH_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define TSH_ASSERT_NEVER(lbl, cond)
`define TSH_ASSERT_NEXT(lbl, a, b)
`endif
`endif

@@ sv/tsh_pkg.sv @@
// Types and constants of the TCP SYN header extractor.
`default_nettype none
package tsh_pkg;
	localparam int MAX_OPTION_BYTES = 40;
	localparam int MAX_VLAN_TAGS = 2;
	localparam logic [15:0] DEST_PORT_RST = 16'd443;
	localparam logic [31:0] DEST_IPV4_RST = 32'h7F00_0001;
	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam int TDATA_W = 248;

	localparam logic [2:0] REG_DEST_PORT = 3'd0;
	localparam logic [2:0] REG_CHECK_ADDR = 3'd1;
	localparam logic [2:0] REG_DEST_IPV4 = 3'd2;
	localparam logic [2:0] REG_IPV6_UPPER = 3'd3;
	localparam logic [2:0] REG_IPV6_LOWER = 3'd4;

	typedef enum logic [7:0] {
		PH_ETH    = 8'b0000_0001,
		PH_VLAN   = 8'b0000_0010,
		PH_IP4    = 8'b0000_0100,
		PH_IP4OPT = 8'b0000_1000,
		PH_IP6    = 8'b0001_0000,
		PH_TCP    = 8'b0010_0000,
		PH_OPTS   = 8'b0100_0000,
		PH_IDLE   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [15:0]  dest_port;
		logic         check_dest_addr;
		logic [31:0]  dest_ipv4;
		logic [127:0] dest_ipv6;
	} cfg_t;

	typedef struct packed {
		logic        item_kind;
		logic        run_last;
		logic [63:0] source_addr_upper;
		logic [63:0] source_addr_lower;
		logic [15:0] source_port;
		logic [31:0] sequence_res;
		logic [15:0] window;
		logic [5:0]  options_length;
		logic [7:0]  hop_ttl;
		logic        is_ipv6;
		logic [31:0] syn_tick;
		logic [5:0]  option_index;
	} result_t;
endpackage
`default_nettype wire

@@ sv/tcp_syn_header_extractor_top.sv @@
// Top level of the TCP SYN header extractor.
// Usage: Ethernet frames enter one byte per request on the s_ channel
// (s_tdata = byte, s_tlast = last byte of the frame). For a TCP SYN to the
// configured port the block emits one handshake record on the m_ channel
// (m_tuser = 0), followed by one request per TCP option byte (m_tuser = 1),
// up to 40, with m_tlast on the last result of the packet.
// Each byte is parsed in the cycle it is taken; its result is registered and
// shows on m_tvalid. One byte is taken every cycle while s_tready is high.
// A two-entry result buffer keeps s_tready high while a result waits; when
// the receiver stalls and the buffer holds two results, s_tready drops.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data,
// always ready; the user must write them only while the block is idle (unenforced).
// Reset clears the parse state, the SYN counter and the result buffer and
// loads the configuration defaults (port 443, IPv4 127.0.0.1, no address
// check). No clearing pass is needed after reset.
`default_nettype none
module tcp_syn_header_extractor_top #(
	parameter int MAX_OPTION_BYTES = tsh_pkg::MAX_OPTION_BYTES,
	parameter int MAX_VLAN_TAGS = tsh_pkg::MAX_VLAN_TAGS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [63:0] source_addr_upper, [127:64] source_addr_lower, [143:128] source_port,
	// [175:144] sequence_res, [191:176] window, [197:192] options_length,
	// [205:198] hop_ttl, [206] is_ipv6, [238:207] syn_tick, [244:239] option_index
	output logic [tsh_pkg::TDATA_W-1:0] m_tdata,
	output logic             m_tuser,   // [0] item_kind
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	tsh_pkg::cfg_t cfg_q;
	tsh_pkg::result_t res, head;
	logic res_valid, take, full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_port <= tsh_pkg::DEST_PORT_RST;
			cfg_q.check_dest_addr <= 1'b0;
			cfg_q.dest_ipv4 <= tsh_pkg::DEST_IPV4_RST;
			cfg_q.dest_ipv6 <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tsh_pkg::REG_DEST_PORT: cfg_q.dest_port <= cfg_data[15:0];
				tsh_pkg::REG_CHECK_ADDR: cfg_q.check_dest_addr <= cfg_data[0];
				tsh_pkg::REG_DEST_IPV4: cfg_q.dest_ipv4 <= cfg_data[31:0];
				tsh_pkg::REG_IPV6_UPPER: cfg_q.dest_ipv6[127:64] <= cfg_data;
				tsh_pkg::REG_IPV6_LOWER: cfg_q.dest_ipv6[63:0] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !full;
	assign take = s_tvalid && s_tready;

	tsh_parser #(
		.MAX_OPTION_BYTES(MAX_OPTION_BYTES),
		.MAX_VLAN_TAGS(MAX_VLAN_TAGS)
	) u_parser (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_take(take), .in_byte(s_tdata), .in_end(s_tlast),
		.res_valid(res_valid), .res(res)
	);

	tsh_out_buf u_buf (
		.clk(clk), .arst_n(arst_n),
		.push(take && res_valid), .push_data(res),
		.pop(m_tvalid && m_tready), .full(full),
		.head_valid(m_tvalid), .head(head)
	);

	assign m_tuser = head.item_kind;
	assign m_tlast = head.run_last;
	assign m_tdata = {3'b000, head.option_index, head.syn_tick, head.is_ipv6, head.hop_ttl,
		head.options_length, head.window, head.sequence_res, head.source_port,
		head.source_addr_lower, head.source_addr_upper};
endmodule
`default_nettype wire

@@ sv/tsh_parser.sv @@
// Byte-wise header parser: frame state, field capture and result forming.
`default_nettype none
module tsh_parser #(
	parameter int MAX_OPTION_BYTES = tsh_pkg::MAX_OPTION_BYTES,
	parameter int MAX_VLAN_TAGS = tsh_pkg::MAX_VLAN_TAGS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tsh_pkg::cfg_t   cfg,
	input  wire logic            in_take,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_end,
	output logic                 res_valid,
	output tsh_pkg::result_t     res
);
	tsh_pkg::phase_t phase_q, phase_d;
	logic [7:0] off_q, start_q, start_d;
	logic [15:0] etype_q, etype_d;
	logic [1:0] tags_q, tags_d;
	logic [127:0] src_q, src_d;
	logic [3:0] ihl_q, ihl_d, doff_q, doff_d;
	logic [15:0] fdp_q, fdp_d, sport_q, sport_d, win_q, win_d;
	logic [7:0] ttl_q, ttl_d, proto_q, proto_d, flags_q, flags_d;
	logic is6_q, is6_d, dm_q, dm_d;
	logic [31:0] seq_q, seq_d, cnt_q, cnt_d;
	logic [7:0] rel;
	logic [8:0] rel_p1;
	logic [5:0] len, lim, ip4opt_len;
	logic [15:0] et_new;
	logic [3:0] k6;
	logic byte_ok4, byte_ok6, tcp_ok;

	assign rel = off_q - start_q;
	assign rel_p1 = {1'b0, rel} + 9'd1;
	assign len = {doff_q, 2'b00} - 6'd20;
	assign lim = (len < 6'(MAX_OPTION_BYTES)) ? len : 6'(MAX_OPTION_BYTES);
	assign ip4opt_len = {ihl_q, 2'b00} - 6'd20;
	assign et_new = {etype_q[15:8], in_byte};
	assign k6 = 4'(rel - 8'd24);
	assign byte_ok4 = cfg.dest_ipv4[{~rel[1:0], 3'b000} +: 8] == in_byte;
	assign byte_ok6 = cfg.dest_ipv6[{~k6, 3'b000} +: 8] == in_byte;
	assign tcp_ok = (fdp_q == cfg.dest_port) && flags_q[1] && !flags_q[4] && (doff_q >= 4'd5);

	always_comb begin
		phase_d = phase_q; start_d = start_q; etype_d = etype_q; tags_d = tags_q;
		src_d = src_q; ihl_d = ihl_q; doff_d = doff_q; fdp_d = fdp_q;
		sport_d = sport_q; win_d = win_q; ttl_d = ttl_q; proto_d = proto_q;
		flags_d = flags_q; is6_d = is6_q; dm_d = dm_q; seq_d = seq_q; cnt_d = cnt_q;
		res_valid = 1'b0;
		res = '0;
		case (phase_q)
			tsh_pkg::PH_ETH, tsh_pkg::PH_VLAN: begin
				if (rel == ((phase_q == tsh_pkg::PH_ETH) ? 8'd12 : 8'd2))
					etype_d = {in_byte, etype_q[7:0]};
				if (rel == ((phase_q == tsh_pkg::PH_ETH) ? 8'd13 : 8'd3)) begin
					etype_d = et_new;
					start_d = off_q + 8'd1;
					if ((et_new == tsh_pkg::ETYPE_VLAN || et_new == tsh_pkg::ETYPE_QINQ)
							&& ({30'd0, tags_q} < MAX_VLAN_TAGS)) begin
						tags_d = tags_q + 2'd1;
						phase_d = tsh_pkg::PH_VLAN;
					end else if (et_new == tsh_pkg::ETYPE_IPV4) begin
						phase_d = tsh_pkg::PH_IP4;
					end else if (et_new == tsh_pkg::ETYPE_IPV6) begin
						phase_d = tsh_pkg::PH_IP6;
					end else begin
						start_d = start_q;
						phase_d = tsh_pkg::PH_IDLE;
					end
				end
			end
			tsh_pkg::PH_IP4: begin
				if (rel == 8'd0) ihl_d = in_byte[3:0];
				if (rel == 8'd6) fdp_d[15:8] = in_byte;
				if (rel == 8'd7) fdp_d[7:0] = in_byte;
				if (rel == 8'd8) ttl_d = in_byte;
				if (rel == 8'd9) proto_d = in_byte;
				if (rel >= 8'd12 && rel <= 8'd15)
					src_d[{2'b11, ~rel[1:0], 3'b000} +: 8] = in_byte;
				if (rel >= 8'd16 && rel <= 8'd19 && !byte_ok4) dm_d = 1'b0;
				if (rel == 8'd19) begin
					if ((fdp_q[13:0] == 14'd0) && (proto_q == tsh_pkg::PROTO_TCP)
							&& (ihl_q >= 4'd5) && (!cfg.check_dest_addr || dm_d)) begin
						start_d = off_q + 8'd1;
						phase_d = (ihl_q == 4'd5) ? tsh_pkg::PH_TCP : tsh_pkg::PH_IP4OPT;
					end else begin
						phase_d = tsh_pkg::PH_IDLE;
					end
				end
			end
			tsh_pkg::PH_IP4OPT: begin
				if (rel_p1 >= {3'd0, ip4opt_len}) begin
					start_d = off_q + 8'd1;
					phase_d = tsh_pkg::PH_TCP;
				end
			end
			tsh_pkg::PH_IP6: begin
				if (rel == 8'd0) is6_d = 1'b1;
				if (rel == 8'd6) proto_d = in_byte;
				if (rel == 8'd7) ttl_d = in_byte;
				// Source bytes 0..7 land in the upper word, bytes 8..15 in the lower one.
				if (rel >= 8'd8 && rel <= 8'd23)
					src_d[{rel[3], ~rel[2:0], 3'b000} +: 8] = in_byte;
				if (rel >= 8'd24 && rel <= 8'd39 && !byte_ok6) dm_d = 1'b0;
				if (rel == 8'd39) begin
					if ((proto_q == tsh_pkg::PROTO_TCP) && (!cfg.check_dest_addr || dm_d)) begin
						start_d = off_q + 8'd1;
						phase_d = tsh_pkg::PH_TCP;
					end else begin
						phase_d = tsh_pkg::PH_IDLE;
					end
				end
			end
			tsh_pkg::PH_TCP: begin
				if (rel == 8'd0) sport_d[15:8] = in_byte;
				if (rel == 8'd1) sport_d[7:0] = in_byte;
				if (rel == 8'd2) fdp_d[15:8] = in_byte;
				if (rel == 8'd3) fdp_d[7:0] = in_byte;
				if (rel >= 8'd4 && rel <= 8'd7) seq_d[{~rel[1:0], 3'b000} +: 8] = in_byte;
				if (rel == 8'd12) doff_d = in_byte[7:4];
				if (rel == 8'd13) flags_d = in_byte;
				if (rel == 8'd14) win_d[15:8] = in_byte;
				if (rel == 8'd15) win_d[7:0] = in_byte;
				if (rel == 8'd19) begin
					if (tcp_ok) begin
						cnt_d = cnt_q + 32'd1;
						res_valid = 1'b1;
						res.run_last = in_end || (lim == 6'd0);
						res.source_addr_upper = src_q[127:64];
						res.source_addr_lower = src_q[63:0];
						res.source_port = sport_q;
						res.sequence_res = seq_q;
						res.window = win_q;
						res.options_length = len;
						res.hop_ttl = ttl_q;
						res.is_ipv6 = is6_q;
						res.syn_tick = cnt_d;
						if (lim == 6'd0) begin
							phase_d = tsh_pkg::PH_IDLE;
						end else begin
							start_d = off_q + 8'd1;
							phase_d = tsh_pkg::PH_OPTS;
						end
					end else begin
						phase_d = tsh_pkg::PH_IDLE;
					end
				end
			end
			tsh_pkg::PH_OPTS: begin
				res_valid = 1'b1;
				res.item_kind = 1'b1;
				res.run_last = in_end || (rel_p1 >= {3'd0, lim});
				res.hop_ttl = in_byte;
				res.option_index = rel[5:0];
				if (rel_p1 >= {3'd0, lim}) phase_d = tsh_pkg::PH_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsh_pkg::PH_ETH;
			off_q <= '0; start_q <= '0; etype_q <= '0; tags_q <= '0; src_q <= '0;
			ihl_q <= '0; doff_q <= '0; fdp_q <= '0; sport_q <= '0; win_q <= '0;
			ttl_q <= '0; proto_q <= '0; flags_q <= '0; is6_q <= 1'b0; dm_q <= 1'b1;
			seq_q <= '0; cnt_q <= '0;
		end else if (in_take) begin
			cnt_q <= cnt_d;
			if (in_end) begin
				phase_q <= tsh_pkg::PH_ETH;
				off_q <= '0; start_q <= '0; etype_q <= '0; tags_q <= '0; src_q <= '0;
				ihl_q <= '0; doff_q <= '0; fdp_q <= '0; sport_q <= '0; win_q <= '0;
				ttl_q <= '0; proto_q <= '0; flags_q <= '0; is6_q <= 1'b0; dm_q <= 1'b1;
				seq_q <= '0;
			end else begin
				phase_q <= phase_d;
				if (off_q != 8'hFF) off_q <= off_q + 8'd1;
				start_q <= start_d; etype_q <= etype_d; tags_q <= tags_d; src_q <= src_d;
				ihl_q <= ihl_d; doff_q <= doff_d; fdp_q <= fdp_d; sport_q <= sport_d;
				win_q <= win_d; ttl_q <= ttl_d; proto_q <= proto_d; flags_q <= flags_d;
				is6_q <= is6_d; dm_q <= dm_d; seq_q <= seq_d;
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/tsh_out_buf.sv @@
// Two-entry result buffer between the parser and the output stream.
`default_nettype none
`include "tcp_syn_header_extractor_top_macros.svh"
module tsh_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tsh_pkg::result_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  head_valid,
	output tsh_pkg::result_t      head
);
	tsh_pkg::result_t ent0_q, ent1_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Entry 0 is always the oldest request.
	always_ff @(posedge clk) begin
		if (pop) begin
			ent0_q <= (cnt_q == 2'd2) ? ent1_q : push_data;
			if (push) ent1_q <= push_data;
		end else if (push) begin
			if (cnt_q == 2'd0) ent0_q <= push_data;
			else ent1_q <= push_data;
		end
	end

	`TSH_ASSERT_NEVER(a_no_overflow, push && full && !pop)
	`TSH_ASSERT_NEVER(a_no_underflow, pop && !head_valid)
	`TSH_ASSERT_NEXT(a_drain, pop && !push && (cnt_q == 2'd1), !head_valid)
endmodule
`default_nettype wire

@@ verif/tb_tcp_syn_header_extractor_top.sv @@
// Self-checking testbench for the TCP SYN header extractor top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_tcp_syn_header_extractor_top;
	typedef struct {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	typedef struct {
		logic                         kind;
		logic                         last;
		logic [tsh_pkg::TDATA_W-1:0]  data;
	} syn_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [tsh_pkg::TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	tcp_syn_header_extractor_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state.
	logic [15:0]      p_dport;
	logic             p_chk;
	logic [31:0]      p_dip4;
	logic [63:0]      p_dip6_hi, p_dip6_lo;
	logic [7:0]       ofs, lstart;
	tsh_pkg::phase_t  phase;
	logic [15:0]      etype;
	logic [63:0]      src_hi, src_lo, hdr0, hdr1;
	logic             dmatch;
	logic [31:0]      syn_count;
	int               tags;

	frame_byte_t  pending_bytes[$];
	syn_result_t  expected_results[$];
	int           errors = 0;
	int           results_seen = 0;

	function automatic void clear_frame();
		ofs = 0; phase = tsh_pkg::PH_ETH; lstart = 0; etype = 0;
		src_hi = 0; src_lo = 0; hdr0 = 0; hdr1 = 0; dmatch = 1; tags = 0;
	endfunction

	function automatic void enter_layer(tsh_pkg::phase_t ph);
		phase = ph;
		lstart = ofs + 8'd1;
	endfunction

	function automatic void route_ethertype();
		if ((etype == tsh_pkg::ETYPE_VLAN || etype == tsh_pkg::ETYPE_QINQ)
				&& tags < tsh_pkg::MAX_VLAN_TAGS) begin
			tags++;
			enter_layer(tsh_pkg::PH_VLAN);
		end else if (etype == tsh_pkg::ETYPE_IPV4) begin
			enter_layer(tsh_pkg::PH_IP4);
		end else if (etype == tsh_pkg::ETYPE_IPV6) begin
			enter_layer(tsh_pkg::PH_IP6);
		end else begin
			phase = tsh_pkg::PH_IDLE;
		end
	endfunction

	function automatic int option_cap();
		int len;
		len = int'(hdr1[59:56]) * 4 - 20;
		return len < tsh_pkg::MAX_OPTION_BYTES ? len : tsh_pkg::MAX_OPTION_BYTES;
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic fin);
		int rel, k, lim, ihl;
		logic [63:0] w;
		logic ok;
		syn_result_t r;
		rel = int'(8'(ofs - lstart));
		case (phase)
			tsh_pkg::PH_ETH: begin
				if (rel == 12) etype[15:8] = b;
				if (rel == 13) begin
					etype[7:0] = b;
					route_ethertype();
				end
			end
			tsh_pkg::PH_VLAN: begin
				if (rel == 2) etype[15:8] = b;
				if (rel == 3) begin
					etype[7:0] = b;
					route_ethertype();
				end
			end
			tsh_pkg::PH_IP4: begin
				if (rel == 0) hdr1[31:24] = {4'd0, b[3:0]};
				else if (rel == 6) hdr1[47:40] = b;
				else if (rel == 7) hdr1[39:32] = b;
				else if (rel == 8) hdr1[7:0] = b;
				else if (rel == 9) hdr1[23:16] = b;
				else if (rel >= 12 && rel <= 15) src_hi[63 - 8 * (rel - 12) -: 8] = b;
				else if (rel >= 16 && rel <= 19) begin
					if (p_dip4[31 - 8 * (rel - 16) -: 8] != b) dmatch = 0;
				end
				if (rel == 19) begin
					ihl = int'(hdr1[27:24]);
					ok = hdr1[45:32] == 0 && hdr1[23:16] == tsh_pkg::PROTO_TCP && ihl >= 5
						&& (!p_chk || dmatch);
					if (!ok) phase = tsh_pkg::PH_IDLE;
					else enter_layer(ihl == 5 ? tsh_pkg::PH_TCP : tsh_pkg::PH_IP4OPT);
				end
			end
			tsh_pkg::PH_IP4OPT: begin
				if (rel + 1 >= (int'(hdr1[27:24]) - 5) * 4) enter_layer(tsh_pkg::PH_TCP);
			end
			tsh_pkg::PH_IP6: begin
				if (rel == 0) hdr1[15:8] = 8'd1;
				else if (rel == 6) hdr1[23:16] = b;
				else if (rel == 7) hdr1[7:0] = b;
				else if (rel >= 8 && rel <= 23) begin
					k = rel - 8;
					if (k < 8) src_hi[63 - 8 * k -: 8] = b;
					else src_lo[63 - 8 * (k - 8) -: 8] = b;
				end else if (rel >= 24 && rel <= 39) begin
					k = rel - 24;
					w = k < 8 ? p_dip6_hi : p_dip6_lo;
					if (w[63 - 8 * (k % 8) -: 8] != b) dmatch = 0;
				end
				if (rel == 39) begin
					if (hdr1[23:16] == tsh_pkg::PROTO_TCP && (!p_chk || dmatch))
						enter_layer(tsh_pkg::PH_TCP);
					else phase = tsh_pkg::PH_IDLE;
				end
			end
			tsh_pkg::PH_TCP: begin
				if (rel == 0) hdr0[63:56] = b;
				else if (rel == 1) hdr0[55:48] = b;
				else if (rel == 2) hdr1[47:40] = b;
				else if (rel == 3) hdr1[39:32] = b;
				else if (rel >= 4 && rel <= 7) hdr0[47 - 8 * (rel - 4) -: 8] = b;
				else if (rel == 12) hdr1[63:56] = {4'd0, b[7:4]};
				else if (rel == 13) hdr1[55:48] = b;
				else if (rel == 14) hdr0[15:8] = b;
				else if (rel == 15) hdr0[7:0] = b;
				if (rel == 19) begin
					ok = hdr1[47:32] == p_dport && hdr1[49] && !hdr1[52] && hdr1[59:56] >= 5;
					if (!ok) begin
						phase = tsh_pkg::PH_IDLE;
					end else begin
						lim = option_cap();
						syn_count++;
						r.kind = 1'b0;
						r.last = fin || lim == 0;
						r.data = '0;
						r.data[63:0] = src_hi;
						r.data[127:64] = src_lo;
						r.data[143:128] = hdr0[63:48];
						r.data[175:144] = hdr0[47:16];
						r.data[191:176] = hdr0[15:0];
						r.data[197:192] = 6'(int'(hdr1[59:56]) * 4 - 20);
						r.data[205:198] = hdr1[7:0];
						r.data[206] = hdr1[8];
						r.data[238:207] = syn_count;
						expected_results.push_back(r);
						if (lim == 0) phase = tsh_pkg::PH_IDLE;
						else enter_layer(tsh_pkg::PH_OPTS);
					end
				end
			end
			tsh_pkg::PH_OPTS: begin
				lim = option_cap();
				r.kind = 1'b1;
				r.last = fin || rel + 1 >= lim;
				r.data = '0;
				r.data[205:198] = b;
				r.data[244:239] = 6'(rel);
				expected_results.push_back(r);
				if (rel + 1 >= lim) phase = tsh_pkg::PH_IDLE;
			end
			default: ;
		endcase
		if (fin) clear_frame();
		else if (ofs < 8'd255) ofs++;
	endfunction

	task automatic report_mismatch(string what, logic [tsh_pkg::TDATA_W-1:0] got,
			logic [tsh_pkg::TDATA_W-1:0] want);
		$display("mismatch on %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// Driver: feeds queued bytes with a random gap before each one.
	int gap_in = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
				gap_in = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) gap_in = 0;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_bytes.size() > 0 && gap_in == 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_bytes[0].data;
					s_tlast <= pending_bytes[0].last;
					void'(pending_bytes.pop_front());
				end else begin
					s_tvalid <= 1'b0;
					if (gap_in > 0) gap_in--;
				end
			end
		end
	end

	// Monitor: random receiver stalls and comparison against predictions.
	int gap_out = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					if (m_tuser !== expected_results[0].kind)
						report_mismatch("item kind", m_tuser, expected_results[0].kind);
					if (m_tlast !== expected_results[0].last)
						report_mismatch("last flag", m_tlast, expected_results[0].last);
					if (m_tdata !== expected_results[0].data)
						report_mismatch("result data", m_tdata, expected_results[0].data);
					void'(expected_results.pop_front());
				end
				gap_out = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) gap_out = 0;
			end
			if (gap_out > 0) begin
				m_tready <= 1'b0;
				gap_out--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// The channel is left idle after each write before the task returns.
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			tsh_pkg::REG_DEST_PORT:  p_dport = val[15:0];
			tsh_pkg::REG_CHECK_ADDR: p_chk = val[0];
			tsh_pkg::REG_DEST_IPV4:  p_dip4 = val[31:0];
			tsh_pkg::REG_IPV6_UPPER: p_dip6_hi = val;
			tsh_pkg::REG_IPV6_LOWER: p_dip6_lo = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic void push_byte(logic [7:0] b, logic fin = 1'b0);
		frame_byte_t f;
		f.data = b;
		f.last = fin;
		pending_bytes.push_back(f);
	endfunction

	function automatic void push_word(logic [63:0] v, int n);
		for (int i = n - 1; i >= 0; i--) push_byte(v[8 * i +: 8]);
	endfunction

	// Builds one frame; fault selects a field to break, cut truncates the frame.
	function automatic void build_frame(bit v6, int ntags, int ihl, int doff, int fault,
			int cut, int trail);
		frame_byte_t fr[$];
		logic [15:0] dport;
		logic [7:0] flags;
		int nopt;
		fr = pending_bytes;
		pending_bytes = {};
		push_word({$urandom, $urandom}, 6);
		push_word({$urandom, $urandom}, 6);
		for (int t = 0; t < ntags; t++) begin
			push_word($urandom_range(0, 1) ? tsh_pkg::ETYPE_VLAN : tsh_pkg::ETYPE_QINQ, 2);
			push_word($urandom, 2);
		end
		push_word(fault == 1 ? 16'($urandom) :
			(v6 ? tsh_pkg::ETYPE_IPV6 : tsh_pkg::ETYPE_IPV4), 2);
		if (!v6) begin
			push_byte({4'd4, 4'(ihl)});
			push_word($urandom, 5);
			push_word(fault == 2 ? 16'($urandom) : {$urandom_range(0, 3) == 0, 1'b0, 14'd0}, 2);
			push_byte($urandom);
			push_byte(fault == 3 ? 8'($urandom) : tsh_pkg::PROTO_TCP);
			push_word($urandom, 2);
			push_word($urandom, 4);
			push_word(p_chk && fault != 4 ? 64'(p_dip4) : 64'($urandom), 4);
			for (int i = 0; i < (ihl - 5) * 4; i++) push_byte($urandom);
		end else begin
			push_word({$urandom, $urandom}, 6);
			push_byte(fault == 3 ? 8'($urandom) : tsh_pkg::PROTO_TCP);
			push_byte($urandom);
			push_word({$urandom, $urandom}, 8);
			push_word({$urandom, $urandom}, 8);
			if (p_chk && fault != 4) begin
				push_word(p_dip6_hi, 8);
				push_word(p_dip6_lo, 8);
			end else begin
				push_word({$urandom, $urandom}, 8);
				push_word({$urandom, $urandom}, 8);
			end
		end
		dport = fault == 5 ? 16'($urandom) : p_dport;
		flags = $urandom;
		if (fault != 6) flags = (flags | 8'h02) & ~8'h10;
		push_word($urandom, 2);
		push_word(dport, 2);
		push_word($urandom, 4);
		push_word($urandom, 4);
		push_byte({4'(doff), 4'($urandom)});
		push_byte(flags);
		push_word($urandom, 6);
		nopt = doff * 4 - 20;
		if (nopt < 0) nopt = 0;
		for (int i = 0; i < nopt + trail; i++) push_byte($urandom);
		if (cut > 0 && cut < pending_bytes.size())
			pending_bytes = pending_bytes[0:cut - 1];
		pending_bytes[$].last = 1'b1;
		pending_bytes = {fr, pending_bytes};
	endfunction

	function automatic void random_frame();
		int fault, cut, ntags;
		fault = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 6);
		cut = $urandom_range(0, 7) == 0 ? $urandom_range(1, 80) : 0;
		ntags = $urandom_range(0, 5) == 0 ? 3 : $urandom_range(0, 2);
		build_frame($urandom_range(0, 1), ntags, $urandom_range(0, 7) == 0 ?
			$urandom_range(0, 15) : 5, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) :
			$urandom_range(5, 8), fault, cut, $urandom_range(0, 3));
	endfunction

	int sent;

	initial begin
		p_dport = tsh_pkg::DEST_PORT_RST; p_chk = 0; p_dip4 = tsh_pkg::DEST_IPV4_RST;
		p_dip6_hi = 0; p_dip6_lo = 0; syn_count = 0;
		clear_frame();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed frames: plain, tagged, IP options, no options, max options, faults.
		build_frame(0, 0, 5, 5, 0, 0, 0);
		build_frame(1, 2, 5, 15, 0, 0, 2);
		build_frame(0, 1, 15, 8, 0, 0, 0);
		build_frame(0, 3, 5, 6, 0, 0, 0);
		build_frame(0, 0, 4, 6, 0, 0, 0);
		build_frame(1, 0, 5, 4, 0, 0, 0);
		build_frame(0, 0, 5, 10, 0, 60, 0);
		for (int f = 1; f <= 6; f++) build_frame(f % 2, 0, 5, 6, f, 0, 0);
		push_byte(8'hFF, 1'b1);
		wait_idle();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(tsh_pkg::REG_DEST_PORT, 64'hFFFF);
					write_reg(tsh_pkg::REG_CHECK_ADDR, 64'd1);
					write_reg(tsh_pkg::REG_DEST_IPV4, 64'hFFFF_FFFF);
					write_reg(tsh_pkg::REG_IPV6_UPPER, '1);
					write_reg(tsh_pkg::REG_IPV6_LOWER, '1);
				end
				1: begin
					write_reg(tsh_pkg::REG_DEST_PORT, 64'd0);
					write_reg(tsh_pkg::REG_DEST_IPV4, 64'd0);
					write_reg(tsh_pkg::REG_IPV6_UPPER, 64'd0);
					write_reg(tsh_pkg::REG_IPV6_LOWER, 64'd0);
				end
				default: begin
					write_reg(tsh_pkg::REG_DEST_PORT, {$urandom, $urandom});
					write_reg(tsh_pkg::REG_CHECK_ADDR, $urandom_range(0, 1));
					write_reg(tsh_pkg::REG_DEST_IPV4, {$urandom, $urandom});
					write_reg(tsh_pkg::REG_IPV6_UPPER, {$urandom, $urandom});
					write_reg(tsh_pkg::REG_IPV6_LOWER, {$urandom, $urandom});
				end
			endcase
			sent = 0;
			while (sent < 40) begin
				random_frame();
				sent += pending_bytes.size();
				while (pending_bytes.size() > 0) @(posedge clk);
			end
			wait_idle();
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
